// ===== rtl/core/dfd_pkg.sv =====
package dfd_pkg;

  typedef enum logic [2:0] {
    PH_ID      = 3'd0,
    PH_SEQ     = 3'd1,
    PH_FLAGS   = 3'd2,
    PH_LEN     = 3'd3,
    PH_SKIP    = 3'd4,
    PH_SPLIT   = 3'd5,
    PH_PAYLOAD = 3'd6,
    PH_DISCARD = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ABORT   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CLASS_USER     = 2'd0,
    CLASS_INTERNAL = 2'd1,
    CLASS_SPLIT    = 2'd2
  } class_e;

  localparam logic [7:0] IdLow      = 8'h80;
  localparam logic [7:0] IdHigh     = 8'h8f;
  localparam logic [3:0] SeqBytes   = 4'd3;
  localparam logic [3:0] LenBytes   = 4'd2;
  localparam logic [3:0] SplitBytes = 4'd10;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [23:0] ack_sequence;
    logic [2:0]  reliability;
    class_e      frame_class;
    logic [31:0] fragment_count;
    logic [15:0] fragment_group;
    logic [31:0] fragment_index;
    logic        frame_first;
    logic        frame_last;
    logic        run_last;
  } res_t;

  // Index bytes that follow the bit length: message index (3) and
  // order index plus channel (4), by reliability code.
  function automatic logic [3:0] skip_bytes(input logic [2:0] rel);
    logic [3:0] k;
    case (rel)
      3'd1:    k = 4'd4;
      3'd2:    k = 4'd3;
      3'd3:    k = 4'd7;
      3'd4:    k = 4'd7;
      3'd6:    k = 4'd3;
      3'd7:    k = 4'd7;
      default: k = 4'd0;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/dfd_if.sv =====
interface dfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_datagram;

  modport source (output valid, output data_byte, output end_of_datagram, input ready);
  modport sink (input valid, input data_byte, input end_of_datagram, output ready);
endinterface

interface dfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [23:0] ack_sequence;
  logic [2:0]  reliability;
  logic [1:0]  frame_class;
  logic [31:0] fragment_count;
  logic [15:0] fragment_group;
  logic [31:0] fragment_index;
  logic        frame_first;
  logic        frame_last;
  logic        run_last;

  modport source (
    output valid, output kind, output payload_byte, output ack_sequence,
    output reliability, output frame_class, output fragment_count,
    output fragment_group, output fragment_index, output frame_first,
    output frame_last, output run_last, input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input ack_sequence,
    input reliability, input frame_class, input fragment_count,
    input fragment_group, input fragment_index, input frame_first,
    input frame_last, input run_last, output ready
  );
endinterface

// ===== rtl/core/dfd_parser.sv =====
module dfd_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      data_byte_i,
  input  logic            end_of_datagram_i,
  output logic [1:0]      res_cnt_o,
  output dfd_pkg::res_t   res0_o,
  output dfd_pkg::res_t   res1_o
);

  dfd_pkg::phase_e phase_q, phase_d;
  logic [3:0]      fbc_q, fbc_d;
  logic [23:0]     seq_q, seq_d;
  logic [2:0]      rel_q, rel_d;
  logic            split_q, split_d;
  logic [15:0]     blen_q, blen_d;
  logic [13:0]     rem_q, rem_d;
  logic [31:0]     scount_q, scount_d;
  logic [15:0]     sid_q, sid_d;
  logic [31:0]     sindex_q, sindex_d;
  dfd_pkg::class_e cls_q, cls_d;
  logic            started_q, started_d;

  logic [1:0]      cnt;
  dfd_pkg::res_t   res0, res1;

  always_comb begin
    logic [3:0]      k;
    logic [16:0]     bits_round;
    logic            first;
    logic            last;
    dfd_pkg::class_e cls_now;
    dfd_pkg::res_t   pay;
    logic            have_pay;

    phase_d    = phase_q;
    fbc_d      = fbc_q;
    seq_d      = seq_q;
    rel_d      = rel_q;
    split_d    = split_q;
    blen_d     = blen_q;
    rem_d      = rem_q;
    scount_d   = scount_q;
    sid_d      = sid_q;
    sindex_d   = sindex_q;
    cls_d      = cls_q;
    started_d  = started_q;
    k          = '0;
    bits_round = '0;
    first      = 1'b0;
    last       = 1'b0;
    cls_now    = cls_q;
    pay        = '0;
    have_pay   = 1'b0;
    res0       = '0;
    res1       = '0;
    cnt        = 2'd0;

    case (phase_q)
      dfd_pkg::PH_ID: begin
        if (data_byte_i inside {[dfd_pkg::IdLow:dfd_pkg::IdHigh]}) begin
          phase_d = dfd_pkg::PH_SEQ;
          fbc_d   = '0;
          seq_d   = '0;
        end else begin
          phase_d = dfd_pkg::PH_DISCARD;
        end
      end
      dfd_pkg::PH_SEQ: begin
        // Little-endian sequence number
        case (fbc_q[1:0])
          2'd0:    seq_d[7:0]   = seq_q[7:0] | data_byte_i;
          2'd1:    seq_d[15:8]  = seq_q[15:8] | data_byte_i;
          2'd2:    seq_d[23:16] = seq_q[23:16] | data_byte_i;
          default: seq_d = seq_q;
        endcase
        fbc_d = fbc_q + 4'd1;
        if (fbc_d >= dfd_pkg::SeqBytes) begin
          res0.kind         = dfd_pkg::KIND_ACK;
          res0.ack_sequence = seq_d;
          cnt               = 2'd1;
          phase_d           = dfd_pkg::PH_FLAGS;
        end
      end
      dfd_pkg::PH_FLAGS: begin
        rel_d     = data_byte_i[7:5];
        split_d   = data_byte_i[4];
        blen_d    = '0;
        rem_d     = '0;
        scount_d  = '0;
        sid_d     = '0;
        sindex_d  = '0;
        cls_d     = dfd_pkg::CLASS_USER;
        started_d = 1'b0;
        fbc_d     = '0;
        phase_d   = dfd_pkg::PH_LEN;
      end
      dfd_pkg::PH_LEN: begin
        blen_d = {blen_q[7:0], data_byte_i};
        fbc_d  = fbc_q + 4'd1;
        if (fbc_d >= dfd_pkg::LenBytes) begin
          k          = dfd_pkg::skip_bytes(rel_q);
          bits_round = {1'b0, blen_d} + 17'd7;
          rem_d      = bits_round[16:3];
          if (k != 4'd0) begin
            fbc_d   = k;
            phase_d = dfd_pkg::PH_SKIP;
          end else if (split_q) begin
            fbc_d   = '0;
            phase_d = dfd_pkg::PH_SPLIT;
          end else begin
            phase_d = (rem_d == '0) ? dfd_pkg::PH_FLAGS : dfd_pkg::PH_PAYLOAD;
          end
        end
      end
      dfd_pkg::PH_SKIP: begin
        if (fbc_q != '0) fbc_d = fbc_q - 4'd1;
        if (fbc_d == '0) begin
          if (split_q) begin
            phase_d = dfd_pkg::PH_SPLIT;
          end else begin
            phase_d = (rem_q == '0) ? dfd_pkg::PH_FLAGS : dfd_pkg::PH_PAYLOAD;
          end
        end
      end
      dfd_pkg::PH_SPLIT: begin
        if (fbc_q < 4'd4) begin
          scount_d = {scount_q[23:0], data_byte_i};
        end else if (fbc_q < 4'd6) begin
          sid_d = {sid_q[7:0], data_byte_i};
        end else begin
          sindex_d = {sindex_q[23:0], data_byte_i};
        end
        fbc_d = fbc_q + 4'd1;
        if (fbc_d >= dfd_pkg::SplitBytes) begin
          phase_d = (rem_q == '0) ? dfd_pkg::PH_FLAGS : dfd_pkg::PH_PAYLOAD;
        end
      end
      dfd_pkg::PH_PAYLOAD: begin
        first = !started_q;
        if (first) begin
          if (split_q) begin
            cls_now = dfd_pkg::CLASS_SPLIT;
          end else if (!data_byte_i[7]) begin
            cls_now = dfd_pkg::CLASS_INTERNAL;
          end else begin
            cls_now = dfd_pkg::CLASS_USER;
          end
        end
        cls_d = cls_now;
        if (rem_q != '0) rem_d = rem_q - 14'd1;
        last = (rem_d == '0);
        pay.kind         = dfd_pkg::KIND_PAYLOAD;
        pay.payload_byte = data_byte_i;
        pay.reliability  = rel_q;
        pay.frame_class  = cls_now;
        if (split_q) begin
          pay.fragment_count = scount_q;
          pay.fragment_group = sid_q;
          pay.fragment_index = sindex_q;
        end
        pay.frame_first = first;
        pay.frame_last  = last;
        have_pay        = 1'b1;
        res0            = pay;
        cnt             = 2'd1;
        started_d       = 1'b1;
        if (last) phase_d = dfd_pkg::PH_FLAGS;
      end
      default: begin
      end
    endcase

    if (end_of_datagram_i) begin
      // A frame still open at the end mark gets an abort after any payload
      if (phase_d inside {dfd_pkg::PH_LEN, dfd_pkg::PH_SKIP, dfd_pkg::PH_SPLIT,
                          dfd_pkg::PH_PAYLOAD}) begin
        if (have_pay) begin
          res1             = '0;
          res1.kind        = dfd_pkg::KIND_ABORT;
          res1.reliability = rel_d;
          cnt              = 2'd2;
        end else begin
          res0             = '0;
          res0.kind        = dfd_pkg::KIND_ABORT;
          res0.reliability = rel_d;
          cnt              = 2'd1;
        end
      end
      phase_d = dfd_pkg::PH_ID;
      fbc_d   = '0;
    end

    if (cnt == 2'd1) res0.run_last = 1'b1;
    if (cnt == 2'd2) res1.run_last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= dfd_pkg::PH_ID;
      fbc_q     <= '0;
      seq_q     <= '0;
      rel_q     <= '0;
      split_q   <= 1'b0;
      blen_q    <= '0;
      rem_q     <= '0;
      scount_q  <= '0;
      sid_q     <= '0;
      sindex_q  <= '0;
      cls_q     <= dfd_pkg::CLASS_USER;
      started_q <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      fbc_q     <= fbc_d;
      seq_q     <= seq_d;
      rel_q     <= rel_d;
      split_q   <= split_d;
      blen_q    <= blen_d;
      rem_q     <= rem_d;
      scount_q  <= scount_d;
      sid_q     <= sid_d;
      sindex_q  <= sindex_d;
      cls_q     <= cls_d;
      started_q <= started_d;
    end
  end

  assign res_cnt_o = accept_i ? cnt : 2'd0;
  assign res0_o    = res0;
  assign res1_o    = res1;

  a_pair_is_payload_then_abort: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (res_cnt_o == 2'd2) |->
      (res0_o.kind == dfd_pkg::KIND_PAYLOAD && res1_o.kind == dfd_pkg::KIND_ABORT))
    else $error("two results from one byte must be payload then abort");

  a_end_mark_restarts: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (accept_i && end_of_datagram_i) |=> (phase_q == dfd_pkg::PH_ID && fbc_q == '0))
    else $error("end mark did not return parser to id phase");

  a_seq_count_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (phase_q == dfd_pkg::PH_SEQ) |-> (fbc_q < dfd_pkg::SeqBytes))
    else $error("sequence byte count out of range");

endmodule

// ===== rtl/core/dfd_res_fifo.sv =====
module dfd_res_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    push_cnt_i,
  input  dfd_pkg::res_t push0_i,
  input  dfd_pkg::res_t push1_i,
  output logic          room_o,
  output logic          valid_o,
  input  logic          pop_i,
  output dfd_pkg::res_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dfd_pkg::res_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr_nx = ptr_inc(wr_ptr_q);
  assign pop       = pop_i && valid_o;

  always_comb begin
    case (push_cnt_i)
      2'd1:    wr_ptr_d = wr_ptr_nx;
      2'd2:    wr_ptr_d = ptr_inc(wr_ptr_nx);
      default: wr_ptr_d = wr_ptr_q;
    endcase
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_cnt_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wr_ptr_q] <= push0_i;
    if (push_cnt_i == 2'd2) mem_q[wr_ptr_nx] <= push1_i;
  end

  // Take a byte only when two result slots are free
  assign room_o  = (count_q <= CntW'(Depth - 2));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  a_count_bound: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue count beyond depth");

  a_push_needs_room: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_i != 2'd0) |-> room_o)
    else $error("result pushed without room");

  a_head_held_while_stalled: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !pop_i) |=> (valid_o && $stable(head_o)))
    else $error("result head changed while stalled");

endmodule

// ===== rtl/core/datagram_frame_deframer.sv =====
// Datagram frame deframer: takes one datagram byte per transfer with an
// end mark on the final byte, checks the id byte, emits an acknowledge
// result after the 3-byte sequence number, walks each frame header
// (flags, bit length, index bytes, split header) and emits every payload
// byte with its reliability, class and split fields; a frame cut short by
// the end mark is closed with an abort result. Parsing runs at one byte
// per clock while the queue has room: each accepted byte updates the
// parser state in the same cycle and pushes zero, one or two results
// into an OutDepth-entry result queue. The input is ready whenever the
// queue has two free slots, so with the default depth of 4 a byte enters
// every cycle as long as results drain one per cycle; a byte that yields
// both a payload and an abort result pushes two, and the queue absorbs that.
module datagram_frame_deframer #(
  parameter int unsigned OutDepth = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dfd_in_if.sink   in_i,
  dfd_out_if.source out_o
);

  logic          accept;
  logic          room;
  logic [1:0]    res_cnt;
  dfd_pkg::res_t res0, res1, head;

  assign in_i.ready = room;
  assign accept     = in_i.valid && room;

  dfd_parser u_parser (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .data_byte_i       (in_i.data_byte),
    .end_of_datagram_i (in_i.end_of_datagram),
    .res_cnt_o         (res_cnt),
    .res0_o            (res0),
    .res1_o            (res1)
  );

  dfd_res_fifo #(
    .Depth (OutDepth)
  ) u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (res_cnt),
    .push0_i    (res0),
    .push1_i    (res1),
    .room_o     (room),
    .valid_o    (out_o.valid),
    .pop_i      (out_o.ready),
    .head_o     (head)
  );

  assign out_o.kind           = head.kind;
  assign out_o.payload_byte   = head.payload_byte;
  assign out_o.ack_sequence   = head.ack_sequence;
  assign out_o.reliability    = head.reliability;
  assign out_o.frame_class    = head.frame_class;
  assign out_o.fragment_count = head.fragment_count;
  assign out_o.fragment_group = head.fragment_group;
  assign out_o.fragment_index = head.fragment_index;
  assign out_o.frame_first    = head.frame_first;
  assign out_o.frame_last     = head.frame_last;
  assign out_o.run_last       = head.run_last;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int RandomItems   = 700;
  localparam int HoldCycles    = 120;
  localparam int DrainCycles   = 16;
  localparam int StallLimit    = 2000;
  localparam logic [7:0] InternalBelow = 8'h80;

  typedef struct {
    logic [7:0]    data;
    logic          eod;
    bit            pinned;
    bit            has_result;
    dfd_pkg::res_t result;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  dfd_in_if  in_if ();
  dfd_out_if out_if ();

  datagram_frame_deframer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  dfd_pkg::res_t pending_results[$];
  stim_row_t     stim_rows[$];
  int            mismatch_count = 0;
  bit            idle_enable = 1'b1;
  bit            hold_pending = 1'b0;

  // Parser state mirrored from the block
  dfd_pkg::phase_e prs_phase = dfd_pkg::PH_ID;
  logic [3:0]      hdr_count = '0;
  logic [23:0]     seq_word = '0;
  logic [2:0]      frm_rel = '0;
  logic            frm_split = 1'b0;
  logic [15:0]     len_bits = '0;
  logic [13:0]     left_bytes = '0;
  logic [31:0]     frag_cnt = '0;
  logic [15:0]     frag_grp = '0;
  logic [31:0]     frag_idx = '0;
  dfd_pkg::class_e frm_class = dfd_pkg::CLASS_USER;
  logic            in_payload = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic dfd_pkg::res_t ack_result(input logic [23:0] seq);
    dfd_pkg::res_t r;
    r = '0;
    r.kind = dfd_pkg::KIND_ACK;
    r.ack_sequence = seq;
    r.run_last = 1'b1;
    return r;
  endfunction

  function automatic dfd_pkg::res_t abort_result(input logic [2:0] rel);
    dfd_pkg::res_t r;
    r = '0;
    r.kind = dfd_pkg::KIND_ABORT;
    r.reliability = rel;
    r.run_last = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t plain_row(input logic [7:0] d, input logic e);
    stim_row_t s;
    s = '{data: d, eod: e, pinned: 1'b0, has_result: 1'b0, result: '0};
    return s;
  endfunction

  function automatic stim_row_t pinned_row(input logic [7:0] d, input logic e,
                                           input bit has, input dfd_pkg::res_t r);
    stim_row_t s;
    s = '{data: d, eod: e, pinned: 1'b1, has_result: has, result: r};
    return s;
  endfunction

  // Message index and order index bytes that follow the bit length
  function automatic int index_skip_len(input logic [2:0] rel);
    int k;
    case (rel)
      3'd1:             k = 4;
      3'd2, 3'd6:       k = 3;
      3'd3, 3'd4, 3'd7: k = 7;
      default:          k = 0;
    endcase
    return k;
  endfunction

  function automatic void enter_frame_body();
    if (frm_split) begin
      hdr_count = '0;
      prs_phase = dfd_pkg::PH_SPLIT;
    end else begin
      prs_phase = (left_bytes == 0) ? dfd_pkg::PH_FLAGS : dfd_pkg::PH_PAYLOAD;
    end
  endfunction

  function automatic void deframe_byte(input logic [7:0] b, input logic eod,
                                       ref dfd_pkg::res_t produced[$]);
    dfd_pkg::res_t r;
    int            skip;
    logic          first;
    produced.delete();
    case (prs_phase)
      dfd_pkg::PH_ID: begin
        if (b >= dfd_pkg::IdLow && b <= dfd_pkg::IdHigh) begin
          prs_phase = dfd_pkg::PH_SEQ;
          hdr_count = '0;
          seq_word = '0;
        end else begin
          prs_phase = dfd_pkg::PH_DISCARD;
        end
      end
      dfd_pkg::PH_SEQ: begin
        seq_word = seq_word | (24'(b) << (8 * hdr_count[1:0]));
        hdr_count++;
        if (hdr_count >= dfd_pkg::SeqBytes) begin
          produced.push_back(ack_result(seq_word));
          prs_phase = dfd_pkg::PH_FLAGS;
        end
      end
      dfd_pkg::PH_FLAGS: begin
        frm_rel = b[7:5];
        frm_split = b[4];
        len_bits = '0;
        left_bytes = '0;
        frag_cnt = '0;
        frag_grp = '0;
        frag_idx = '0;
        frm_class = dfd_pkg::CLASS_USER;
        in_payload = 1'b0;
        hdr_count = '0;
        prs_phase = dfd_pkg::PH_LEN;
      end
      dfd_pkg::PH_LEN: begin
        len_bits = {len_bits[7:0], b};
        hdr_count++;
        if (hdr_count >= dfd_pkg::LenBytes) begin
          left_bytes = 14'((17'(len_bits) + 17'd7) >> 3);
          skip = index_skip_len(frm_rel);
          if (skip != 0) begin
            hdr_count = 4'(skip);
            prs_phase = dfd_pkg::PH_SKIP;
          end else begin
            enter_frame_body();
          end
        end
      end
      dfd_pkg::PH_SKIP: begin
        if (hdr_count > 0) hdr_count--;
        if (hdr_count == 0) enter_frame_body();
      end
      dfd_pkg::PH_SPLIT: begin
        if (hdr_count < 4)      frag_cnt = {frag_cnt[23:0], b};
        else if (hdr_count < 6) frag_grp = {frag_grp[7:0], b};
        else                    frag_idx = {frag_idx[23:0], b};
        hdr_count++;
        if (hdr_count >= dfd_pkg::SplitBytes) begin
          prs_phase = (left_bytes == 0) ? dfd_pkg::PH_FLAGS : dfd_pkg::PH_PAYLOAD;
        end
      end
      dfd_pkg::PH_PAYLOAD: begin
        first = !in_payload;
        if (first) begin
          if (frm_split)              frm_class = dfd_pkg::CLASS_SPLIT;
          else if (b < InternalBelow) frm_class = dfd_pkg::CLASS_INTERNAL;
          else                        frm_class = dfd_pkg::CLASS_USER;
        end
        if (left_bytes > 0) left_bytes--;
        r = '0;
        r.kind = dfd_pkg::KIND_PAYLOAD;
        r.payload_byte = b;
        r.reliability = frm_rel;
        r.frame_class = frm_class;
        if (frm_split) begin
          r.fragment_count = frag_cnt;
          r.fragment_group = frag_grp;
          r.fragment_index = frag_idx;
        end
        r.frame_first = first;
        r.frame_last = (left_bytes == 0);
        produced.push_back(r);
        in_payload = 1'b1;
        if (left_bytes == 0) prs_phase = dfd_pkg::PH_FLAGS;
      end
      default: ;
    endcase

    if (eod) begin
      // a frame still open at the end mark is closed by an abort
      if (prs_phase inside {dfd_pkg::PH_LEN, dfd_pkg::PH_SKIP, dfd_pkg::PH_SPLIT,
                            dfd_pkg::PH_PAYLOAD})
        produced.push_back(abort_result(frm_rel));
      prs_phase = dfd_pkg::PH_ID;
      hdr_count = '0;
    end

    if (produced.size() > 0) produced[produced.size() - 1].run_last = 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eod, input bit pinned,
                           input bit has_result, input dfd_pkg::res_t typed);
    dfd_pkg::res_t produced[$];
    while (idle_enable && $urandom_range(99) < 6) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    in_if.end_of_datagram <= eod;
    do @(posedge clk_i); while (!in_if.ready);
    deframe_byte(b, eod, produced);
    if (!pinned) begin
      foreach (produced[i]) pending_results.push_back(produced[i]);
    end else if (has_result) begin
      pending_results.push_back(typed);
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Mostly well-formed datagrams with random content; some foreign ids,
  // some garbage after a good id, some cut short. Returns the number of parsed bytes.
  function automatic int make_datagram(ref logic [7:0] dg[$]);
    int         pick;
    int         nbytes;
    int         bits;
    int         cut;
    bit         cut_short;
    logic [7:0] id;
    logic [7:0] flags;
    dg.delete();
    cut_short = 1'b0;
    pick = $urandom_range(99);
    if (pick < 8) begin
      do id = 8'($urandom_range(255));
      while (id >= dfd_pkg::IdLow && id <= dfd_pkg::IdHigh);
      dg.push_back(id);
      repeat ($urandom_range(5)) dg.push_back(8'($urandom_range(255)));
      return 0;
    end
    dg.push_back(dfd_pkg::IdLow + 8'($urandom_range(15)));
    if (pick < 14) begin
      repeat ($urandom_range(1, 12)) dg.push_back(8'($urandom_range(255)));
      return dg.size();
    end
    repeat (3) dg.push_back(8'($urandom_range(255)));
    for (int f = $urandom_range(3); f > 0 && !cut_short; f--) begin
      flags = 8'($urandom_range(255));
      dg.push_back(flags);
      if ($urandom_range(99) < 4) begin
        bits = $urandom_range(1) ? 16'hffff : $urandom_range(65535);
      end else begin
        nbytes = $urandom_range(6);
        bits = (nbytes == 0) ? 0 : nbytes * 8 - $urandom_range(7);
      end
      dg.push_back(8'(bits >> 8));
      dg.push_back(8'(bits));
      repeat (index_skip_len(flags[7:5])) dg.push_back(8'($urandom_range(255)));
      if (flags[4]) repeat (10) dg.push_back(8'($urandom_range(255)));
      if (bits > 160) begin
        // long frame: end the datagram a few payload bytes in
        repeat ($urandom_range(1, 20)) dg.push_back(8'($urandom_range(255)));
        cut_short = 1'b1;
      end else begin
        repeat ((bits + 7) / 8) dg.push_back(8'($urandom_range(255)));
      end
    end
    if (!cut_short && $urandom_range(99) < 15) begin
      cut = $urandom_range(1, dg.size() - 1);
      while (dg.size() > cut) void'(dg.pop_back());
    end
    return dg.size();
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    dfd_pkg::res_t got;
    dfd_pkg::res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = dfd_pkg::res_t'({out_if.kind, out_if.payload_byte, out_if.ack_sequence,
                             out_if.reliability, out_if.frame_class,
                             out_if.fragment_count, out_if.fragment_group,
                             out_if.fragment_index, out_if.frame_first,
                             out_if.frame_last, out_if.run_last});
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("payload_byte", want.payload_byte, got.payload_byte);
        check_field("ack_sequence", want.ack_sequence, got.ack_sequence);
        check_field("reliability", want.reliability, got.reliability);
        check_field("frame_class", want.frame_class, got.frame_class);
        check_field("fragment_count", want.fragment_count, got.fragment_count);
        check_field("fragment_group", want.fragment_group, got.fragment_group);
        check_field("fragment_index", want.fragment_index, got.fragment_index);
        check_field("frame_first", want.frame_first, got.frame_first);
        check_field("frame_last", want.frame_last, got.frame_last);
        check_field("run_last", want.run_last, got.run_last);
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_pending = 1'b0;
      end
      out_if.ready <= !(idle_enable && $urandom_range(99) < 6);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, StallLimit);
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] dgram[$];
    int         parsed_items;
    bit         held;
    bit         paused;

    parsed_items = 0;
    held = 1'b0;
    paused = 1'b0;
    in_if.valid <= 1'b0;
    in_if.data_byte <= '0;
    in_if.end_of_datagram <= 1'b0;
    rst_ni <= 1'b0;

    // foreign id byte: ignored through its end mark
    stim_rows.push_back(pinned_row(8'h7f, 1'b1, 1'b0, '0));
    // short datagram: ends inside the sequence number
    stim_rows.push_back(pinned_row(8'h80, 1'b0, 1'b0, '0));
    stim_rows.push_back(pinned_row(8'h01, 1'b1, 1'b0, '0));
    // all-ones sequence number
    stim_rows.push_back(plain_row(8'h8f, 1'b0));
    stim_rows.push_back(plain_row(8'hff, 1'b0));
    stim_rows.push_back(plain_row(8'hff, 1'b0));
    stim_rows.push_back(pinned_row(8'hff, 1'b0, 1'b1, ack_result(24'hffffff)));
    // zero-length frame, no index bytes
    stim_rows.push_back(plain_row(8'h00, 1'b0));
    stim_rows.push_back(plain_row(8'h00, 1'b0));
    stim_rows.push_back(plain_row(8'h00, 1'b0));
    // split frame, all-ones split header, one payload byte
    stim_rows.push_back(plain_row(8'h10, 1'b0));
    stim_rows.push_back(plain_row(8'h00, 1'b0));
    stim_rows.push_back(plain_row(8'h01, 1'b0));
    repeat (10) stim_rows.push_back(plain_row(8'hff, 1'b0));
    stim_rows.push_back(plain_row(8'h00, 1'b0));
    // header cut right after the flags byte
    stim_rows.push_back(pinned_row(8'h60, 1'b1, 1'b1, abort_result(3'd3)));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[i])
      send_byte(stim_rows[i].data, stim_rows[i].eod, stim_rows[i].pinned,
                stim_rows[i].has_result, stim_rows[i].result);
    wait_drained();

    while (parsed_items < RandomItems) begin
      idle_enable = !(parsed_items >= 300 && parsed_items < 450);
      if (!held && parsed_items >= 150) begin
        held = 1'b1;
        hold_pending = 1'b1;
      end
      if (!paused && parsed_items >= 550) begin
        paused = 1'b1;
        wait_drained();
      end
      parsed_items += make_datagram(dgram);
      foreach (dgram[i]) send_byte(dgram[i], i == dgram.size() - 1, 1'b0, 1'b0, '0);
    end
    wait_drained();

    if (mismatch_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule
